>>> hw/rtl/fpba_pkg.sv
// Package for the fit-policy block allocator: fit rules, sequencer states,
// operation codes, configuration register indexes and the compare-unit control.
// No dependencies.
package fpba_pkg;

	typedef enum logic [1:0] {
		POL_FIRST = 2'd0,
		POL_BEST  = 2'd1,
		POL_WORST = 2'd2,
		POL_NEXT  = 2'd3
	} policy_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_SCAN  = 2'd1,
		S_DRAIN = 2'd2,
		S_WRITE = 2'd3
	} state_t;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_ACTIVE = 1'b1;

	localparam logic [4:0] ACTIVE_RESET = 5'd16;

	// control for the shared compare unit
	typedef struct packed {
		policy_t policy;
		logic    found;
		logic    go;
	} cmp_ctl_t;

endpackage

>>> hw/rtl/fit_policy_block_allocator.sv
// Fit-policy block allocator: a load beat gives no result. An allocate beat
// scans the active blocks (capped at NUM_BLOCKS) in S_SCAN, one table entry per
// cycle through the RAM read port and the shared compare unit, then passes
// S_DRAIN and S_WRITE; with none active it goes straight to S_WRITE. done pulses
// in S_WRITE and the next beat is taken the cycle after. Results cannot be stalled;
// register writes wait for idle. Reset clears all valid bits, so every entry reads as zero.
module fit_policy_block_allocator #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [3:0]  slot,
	input  logic [15:0] amount,
	// result strobe
	output logic        done,
	output logic        granted,
	output logic [3:0]  chosen_block,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);
	import fpba_pkg::*;

	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
	localparam int ACT_W = (CNT_W > 5) ? CNT_W : 5;

	// configuration registers
	policy_t     policy_q;
	logic [4:0]  active_q;

	// sequencer
	state_t      state_q, state_d;

	// per-request context
	logic [SIZE_BITS-1:0] amt_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     k_q;
	logic [IDX_W-1:0]     ptr_q;
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [SIZE_BITS-1:0] best_val_q;
	logic [IDX_W-1:0]     next_start_q;

	// valid bit per table entry; an entry not yet written reads as zero
	logic [NUM_BLOCKS-1:0] valid_q;

	// read pipeline
	logic                 rd_go_s1;
	logic [IDX_W-1:0]     rd_ptr_s1;
	logic                 rd_vld_s1;
	logic [SIZE_BITS-1:0] rd_data;
	logic [SIZE_BITS-1:0] cand;

	// RAM write port
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [SIZE_BITS-1:0] ram_wdata;

	logic                 accept;
	logic                 load_hit;
	logic                 issue;
	logic                 take;
	logic [CNT_W-1:0]     count_now;
	logic [IDX_W-1:0]     start_ptr;
	logic [IDX_W-1:0]     ptr_next;
	cmp_ctl_t             cmp_ctl;

	// hold register writes off while a scan runs or a command beat is offered
	assign cfg_ready = !busy && !start;
	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;

	// cap the active count at the table size
	always_comb begin
		if (ACT_W'(active_q) > ACT_W'(NUM_BLOCKS)) begin
			count_now = CNT_W'(NUM_BLOCKS);
		end else begin
			count_now = CNT_W'(active_q);
		end
		// next fit resumes at the last grant, unless that block fell out of range
		if (policy_q == POL_NEXT && CNT_W'(next_start_q) < count_now) begin
			start_ptr = next_start_q;
		end else begin
			start_ptr = '0;
		end
	end

	assign load_hit = accept && (op == OP_LOAD) && (32'(slot) < 32'(NUM_BLOCKS));

	// advance the scan pointer, wrapping at the active count
	assign ptr_next = (CNT_W'(ptr_q) + CNT_W'(1) == count_q) ? '0 : ptr_q + IDX_W'(1);

	// next state and sequencer outputs
	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && op == OP_ALLOC) begin
					state_d = (count_now == '0) ? S_WRITE : S_SCAN;
				end
			end
			S_SCAN: begin
				issue = 1'b1;
				if (k_q == count_q - CNT_W'(1)) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_WRITE;
			end
			S_WRITE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIRST;
			active_q <= ACTIVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_POLICY: policy_q <= policy_t'(cfg_data[1:0]);
				REG_ACTIVE: active_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// table storage
	fpba_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (NUM_BLOCKS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ptr_q),
		.rdata (rd_data)
	);

	// write back the shrunk block on a grant, else take a load beat
	always_comb begin
		if (state_q == S_WRITE) begin
			ram_we    = found_q;
			ram_waddr = best_idx_q;
			ram_wdata = best_val_q - amt_q;
		end else begin
			ram_we    = load_hit;
			ram_waddr = IDX_W'(slot);
			ram_wdata = SIZE_BITS'(amount);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end
	end

	// read pipeline: the data for rd_ptr_s1 arrives in the cycle after issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_go_s1 <= 1'b0;
		end else begin
			rd_go_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_ptr_s1 <= ptr_q;
		rd_vld_s1 <= valid_q[ptr_q];
	end

	assign cand = rd_vld_s1 ? rd_data : '0;

	assign cmp_ctl.policy = policy_q;
	assign cmp_ctl.found  = found_q;
	assign cmp_ctl.go     = rd_go_s1;

	fpba_cmp #(
		.SIZE_BITS (SIZE_BITS)
	) u_cmp (
		.ctl  (cmp_ctl),
		.cand (cand),
		.best (best_val_q),
		.amt  (amt_q),
		.take (take)
	);

	// scan context and candidate tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			next_start_q <= '0;
			k_q          <= '0;
			ptr_q        <= '0;
			count_q      <= '0;
		end else begin
			if (accept && op == OP_LOAD) begin
				next_start_q <= '0;
			end else if (accept) begin
				found_q <= 1'b0;
				k_q     <= '0;
				ptr_q   <= start_ptr;
				count_q <= count_now;
			end else if (issue) begin
				k_q   <= k_q + CNT_W'(1);
				ptr_q <= ptr_next;
			end
			if (take) begin
				found_q <= 1'b1;
			end
			if (state_q == S_WRITE && found_q) begin
				next_start_q <= best_idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			amt_q <= SIZE_BITS'(amount);
		end
		if (take) begin
			best_idx_q <= rd_ptr_s1;
			best_val_q <= cand;
		end
	end

	// result beat
	assign done         = (state_q == S_WRITE);
	assign granted      = done && found_q;
	assign chosen_block = granted ? 4'(best_idx_q) : 4'd0;

endmodule

>>> hw/rtl/fpba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/fpba_cmp.sv
// Shared compare unit: decides whether the entry under scan replaces the
// current candidate. Depends on fpba_pkg.
module fpba_cmp #(
	parameter int SIZE_BITS = 16
) (
	input  fpba_pkg::cmp_ctl_t   ctl,
	input  logic [SIZE_BITS-1:0] cand,
	input  logic [SIZE_BITS-1:0] best,
	input  logic [SIZE_BITS-1:0] amt,
	output logic                 take
);
	import fpba_pkg::*;

	logic fits;
	logic better;

	always_comb begin
		fits = (cand >= amt);
		unique case (ctl.policy)
			POL_BEST:  better = (cand < best);
			POL_WORST: better = (cand > best);
			POL_FIRST,
			POL_NEXT:  better = 1'b0;
			default:   better = 1'b0;
		endcase
		// first hit always wins; later hits only replace on a strict win
		take = ctl.go && fits && (!ctl.found || better);
	end

endmodule

>>> hw/rtl/fpba_checker.sv
// Port-level checker for the fit-policy block allocator, bound to the top.
// Depends on fpba_pkg and fit_policy_block_allocator.
module fpba_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       op,
	input logic       done,
	input logic       granted,
	input logic [3:0] chosen_block
);
	import fpba_pkg::*;

	// a result beat only closes an allocation in progress
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result beat while idle");

	a_grant_done: assert property (@(posedge clk) disable iff (!arst_n)
		granted |-> done) else $error("grant without result beat");

	a_nogrant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !granted |-> chosen_block == 4'd0) else $error("index on refusal");

	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && op == OP_ALLOC |=> busy) else $error("allocation not held");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && op == OP_LOAD |=> !done && !busy) else $error("load gave result");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.op           (op),
	.done         (done),
	.granted      (granted),
	.chosen_block (chosen_block)
);
